[src/multi_period_countdown_sequencer_unit_macros.svh]
// Assertion macros shared by the countdown sequencer RTL.
// Depends on nothing; the checks compile away when SYNTHESIS is defined.
`ifndef MULTI_PERIOD_COUNTDOWN_SEQUENCER_UNIT_MACROS_SVH
`define MULTI_PERIOD_COUNTDOWN_SEQUENCER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MPCS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define MPCS_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define MPCS_ASSERT(lbl, clk, rst, prop)
`define MPCS_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

[src/mpcs_pkg.sv]
// Shared constants, codes and payload types of the countdown sequencer.
// Used by every module of the block; depends on nothing.
package mpcs_pkg;

  localparam int MAX_PERIODS = 16;
  localparam int IDX_W = $clog2(MAX_PERIODS);
  localparam int CNT_W = 5;
  localparam int TIME_W = 32;
  localparam int OP_W = 3;
  localparam int EV_W = 2;

  localparam logic [TIME_W-1:0] TICK_STEP_RESET = 32'd1000;
  localparam logic [CNT_W-1:0] PERIODS_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 3'd0,
    OP_START = 3'd1,
    OP_STOP = 3'd2,
    OP_TICK = 3'd3,
    OP_FINISH = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_INACTIVE = 2'd0,
    ST_ACTIVE = 2'd1,
    ST_COMPLETED = 2'd2
  } period_state_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE = 2'd0,
    EV_BEGUN = 2'd1,
    EV_COMPLETED = 2'd2,
    EV_ALL_DONE = 2'd3
  } event_t;

  typedef enum logic {
    CFG_TICK_STEP = 1'b0,
    CFG_PERIODS_IN_USE = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic [IDX_W-1:0] entry_index;
    logic [TIME_W-1:0] duration_value;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] current_index;
    logic [TIME_W-1:0] remaining_now;
    logic [EV_W-1:0] event_code;
    logic running;
  } result_t;

endpackage

[src/multi_period_countdown_sequencer_unit.sv]
// Top level of the multi-period countdown sequencer.
// Depends on mpcs_pkg, mpcs_table and mpcs_out_queue.
//
// Items come in on the item channel (item_valid, item_stall, operation,
// entry_index, duration_value) and each one gives exactly one result on the
// result channel (result_valid, result_stall, current_index, remaining_now,
// event_code, running). A transfer happens on a rising edge with valid high
// and stall low.
// An accepted item is held in the input register, is applied to the period
// table in a single pass and lands in a two-entry result buffer; the result
// leaves only from that buffer. One item per cycle is sustained while the
// buffer is not full; the table read-modify-write sets that figure.
// When the receiver stalls, the buffer holds up to two results and the input
// register a third; after that item_stall rises until results drain.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready: index 0 writes tick_step, index 1 writes periods_in_use.
// Reset sets tick_step to 1000, periods_in_use to 16, all periods inactive,
// the index to zero, the sequencer stopped and both channels empty.
module multi_period_countdown_sequencer_unit (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_stall,
  input  logic [mpcs_pkg::OP_W-1:0] operation,
  input  logic [mpcs_pkg::IDX_W-1:0] entry_index,
  input  logic [mpcs_pkg::TIME_W-1:0] duration_value,
  output logic result_valid,
  input  logic result_stall,
  output logic [mpcs_pkg::CNT_W-1:0] current_index,
  output logic [mpcs_pkg::TIME_W-1:0] remaining_now,
  output logic [mpcs_pkg::EV_W-1:0] event_code,
  output logic running,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [mpcs_pkg::TIME_W-1:0] cfg_data
);
  import mpcs_pkg::*;

  item_t item_reg;
  logic item_reg_valid;
  logic [TIME_W-1:0] tick_step;
  logic [CNT_W-1:0] periods_in_use;
  logic queue_full;
  logic exec;
  logic item_take;
  result_t res;
  result_t head;

  assign cfg_ready = 1'b1;
  assign exec = item_reg_valid && !queue_full;
  assign item_stall = item_reg_valid && queue_full;
  assign item_take = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step <= TICK_STEP_RESET;
      periods_in_use <= PERIODS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_TICK_STEP: tick_step <= cfg_data;
        CFG_PERIODS_IN_USE: periods_in_use <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_reg_valid <= 1'b0;
    end else if (item_take) begin
      item_reg_valid <= 1'b1;
    end else if (exec) begin
      item_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      item_reg.operation <= operation;
      item_reg.entry_index <= entry_index;
      item_reg.duration_value <= duration_value;
    end
  end

  mpcs_table u_table (
    .clk(clk),
    .rst(rst),
    .exec(exec),
    .item(item_reg),
    .tick_step(tick_step),
    .periods_in_use(periods_in_use),
    .res(res)
  );

  mpcs_out_queue u_out_queue (
    .clk(clk),
    .rst(rst),
    .push(exec),
    .push_data(res),
    .full(queue_full),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .head(head)
  );

  assign current_index = head.current_index;
  assign remaining_now = head.remaining_now;
  assign event_code = head.event_code;
  assign running = head.running;

endmodule

[src/mpcs_table.sv]
// Period table with its index and run flag, and the single-pass update per item.
// Depends on mpcs_pkg and the assertion macro header.
`include "multi_period_countdown_sequencer_unit_macros.svh"
module mpcs_table (
  input  logic clk,
  input  logic rst,
  input  logic exec,
  input  mpcs_pkg::item_t item,
  input  logic [mpcs_pkg::TIME_W-1:0] tick_step,
  input  logic [mpcs_pkg::CNT_W-1:0] periods_in_use,
  output mpcs_pkg::result_t res
);
  import mpcs_pkg::*;

  logic [TIME_W-1:0] durations [MAX_PERIODS];
  logic [TIME_W-1:0] remaining [MAX_PERIODS];
  period_state_t states [MAX_PERIODS];
  logic [CNT_W-1:0] active_index;
  logic run_flag;

  logic [CNT_W-1:0] active_index_next;
  logic run_next;
  logic [CNT_W-1:0] count_eff;
  logic [MAX_PERIODS-1:0] cand;
  logic found;
  logic [IDX_W-1:0] sel;
  logic [TIME_W-1:0] rem_old;
  logic [TIME_W-1:0] rem_sub;
  logic dur_we;
  logic rem_we;
  logic [IDX_W-1:0] rem_wa;
  logic [TIME_W-1:0] rem_wd;
  logic st_we;
  logic [IDX_W-1:0] st_wa;
  period_state_t st_wd;
  logic clear_all;
  event_t ev;
  logic [IDX_W-1:0] out_addr;
  logic [TIME_W-1:0] out_rem;

  assign count_eff = (periods_in_use > CNT_W'(MAX_PERIODS)) ? CNT_W'(MAX_PERIODS)
                                                             : periods_in_use;

  always_comb begin
    for (int i = 0; i < MAX_PERIODS; i++) begin
      cand[i] = (CNT_W'(i) >= active_index) && (CNT_W'(i) < count_eff) &&
                (states[i] != ST_COMPLETED);
    end
    found = |cand;
    sel = '0;
    for (int i = MAX_PERIODS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        sel = IDX_W'(i);
      end
    end
  end

  assign rem_old = remaining[sel];
  assign rem_sub = (rem_old >= tick_step) ? (rem_old - tick_step) : '0;

  always_comb begin
    active_index_next = active_index;
    run_next = run_flag;
    ev = EV_NONE;
    dur_we = 1'b0;
    rem_we = 1'b0;
    rem_wa = sel;
    rem_wd = rem_sub;
    st_we = 1'b0;
    st_wa = sel;
    st_wd = ST_ACTIVE;
    clear_all = 1'b0;
    unique case (op_t'(item.operation))
      OP_LOAD: begin
        dur_we = 1'b1;
        rem_we = 1'b1;
        rem_wa = item.entry_index;
        rem_wd = item.duration_value;
      end
      OP_START: begin
        run_next = 1'b1;
        st_we = active_index < count_eff;
        st_wa = active_index[IDX_W-1:0];
        st_wd = ST_ACTIVE;
      end
      OP_STOP: begin
        run_next = 1'b0;
      end
      OP_TICK: begin
        if (run_flag) begin
          if (!found) begin
            run_next = 1'b0;
            ev = EV_ALL_DONE;
            if (active_index < count_eff) begin
              active_index_next = count_eff;
            end
          end else begin
            active_index_next = {1'b0, sel};
            rem_we = 1'b1;
            st_we = 1'b1;
            if (rem_sub == '0) begin
              st_wd = ST_COMPLETED;
              ev = EV_COMPLETED;
            end else begin
              st_wd = ST_ACTIVE;
              ev = (states[sel] == ST_INACTIVE) ? EV_BEGUN : EV_NONE;
            end
          end
        end
      end
      OP_FINISH: begin
        run_next = 1'b0;
        clear_all = 1'b1;
        active_index_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign out_addr = active_index_next[IDX_W-1:0];

  always_comb begin
    if (active_index_next >= CNT_W'(MAX_PERIODS)) begin
      out_rem = '0;
    end else if (rem_we && (rem_wa == out_addr)) begin
      out_rem = rem_wd;
    end else if (clear_all) begin
      out_rem = durations[out_addr];
    end else begin
      out_rem = remaining[out_addr];
    end
  end

  assign res.current_index = active_index_next;
  assign res.remaining_now = out_rem;
  assign res.event_code = ev;
  assign res.running = run_next;

  always_ff @(posedge clk) begin
    if (exec) begin
      if (dur_we) begin
        durations[item.entry_index] <= item.duration_value;
      end
      if (clear_all) begin
        for (int i = 0; i < MAX_PERIODS; i++) begin
          remaining[i] <= durations[i];
        end
      end else if (rem_we) begin
        remaining[rem_wa] <= rem_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PERIODS; i++) begin
        states[i] <= ST_INACTIVE;
      end
      active_index <= '0;
      run_flag <= 1'b0;
    end else if (exec) begin
      if (clear_all) begin
        for (int i = 0; i < MAX_PERIODS; i++) begin
          states[i] <= ST_INACTIVE;
        end
      end else if (st_we) begin
        states[st_wa] <= st_wd;
      end
      active_index <= active_index_next;
      run_flag <= run_next;
    end
  end

  `MPCS_ASSERT(a_finish_rewinds, clk, rst, exec && (item.operation == OP_FINISH) |=> (active_index == '0) && !run_flag)
  `MPCS_ASSERT(a_begun_is_active, clk, rst, exec && (res.event_code == EV_BEGUN) |=> run_flag && (states[active_index[IDX_W-1:0]] == ST_ACTIVE))
  `MPCS_ASSERT(a_idle_tick_holds, clk, rst, exec && !run_flag && (item.operation == OP_TICK) |=> $stable(active_index) && !run_flag)

endmodule

[src/mpcs_out_queue.sv]
// Two-entry result buffer that decouples the result channel from the update logic.
// Depends on mpcs_pkg and the assertion macro header.
`include "multi_period_countdown_sequencer_unit_macros.svh"
module mpcs_out_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  mpcs_pkg::result_t push_data,
  output logic full,
  output logic result_valid,
  input  logic result_stall,
  output mpcs_pkg::result_t head
);
  import mpcs_pkg::*;

  result_t slot0;
  result_t slot1;
  logic [1:0] count;
  logic pop;

  assign result_valid = count != 2'd0;
  assign full = count == 2'd2;
  assign pop = result_valid && !result_stall;
  assign head = slot0;

  always_ff @(posedge clk) begin
    if (push && ((count == 2'd0) || ((count == 2'd1) && pop))) begin
      slot0 <= push_data;
    end else if (pop) begin
      slot0 <= slot1;
    end
    if (push && (count == 2'd1) && !pop) begin
      slot1 <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  `MPCS_ASSERT(a_no_push_when_full, clk, rst, push |-> (count != 2'd2))
  `MPCS_ASSERT(a_pop_drains, clk, rst, pop && !push |=> count == $past(count) - 2'd1)
  `MPCS_ASSERT_NORST(a_reset_empties, clk, rst |=> count == 2'd0)

endmodule

[tb/mpcs_scoreboard_pkg.sv]
// Scoreboard for the countdown sequencer: a cycle-free model of the period
// table that predicts one result per transfer and checks results in order.
// Depends on mpcs_pkg for the codes, the period states and the result type.
package mpcs_scoreboard_pkg;
  import mpcs_pkg::*;

  class countdown_scoreboard;
    logic [TIME_W-1:0] durations [MAX_PERIODS];
    logic [TIME_W-1:0] remaining [MAX_PERIODS];
    period_state_t period_states [MAX_PERIODS];
    logic [CNT_W-1:0] active_index;
    bit run_flag;
    logic [TIME_W-1:0] tick_step;
    logic [CNT_W-1:0] period_count;
    result_t pending_results [$];
    int mismatches;
    int items;
    int checked;
    int completions;
    int all_done_runs;

    function new();
      foreach (period_states[i]) begin
        durations[i] = '0;
        remaining[i] = '0;
        period_states[i] = ST_INACTIVE;
      end
      active_index = '0;
      run_flag = 1'b0;
      tick_step = TICK_STEP_RESET;
      period_count = PERIODS_RESET;
    endfunction

    function result_t advance_sequence(input logic [OP_W-1:0] op,
                                       input logic [IDX_W-1:0] idx,
                                       input logic [TIME_W-1:0] dur);
      result_t r;
      event_t ev;
      int limit;
      limit = (period_count > MAX_PERIODS) ? MAX_PERIODS : int'(period_count);
      ev = EV_NONE;
      case (op)
        OP_LOAD: begin
          durations[idx] = dur;
          remaining[idx] = dur;
        end
        OP_START: begin
          run_flag = 1'b1;
          if (active_index < limit) period_states[active_index] = ST_ACTIVE;
        end
        OP_STOP: run_flag = 1'b0;
        OP_TICK: begin
          if (run_flag) begin
            while (active_index < limit && period_states[active_index] == ST_COMPLETED)
              active_index++;
            if (active_index >= limit) begin
              run_flag = 1'b0;
              ev = EV_ALL_DONE;
            end else begin
              if (period_states[active_index] == ST_INACTIVE) begin
                period_states[active_index] = ST_ACTIVE;
                ev = EV_BEGUN;
              end
              remaining[active_index] = (remaining[active_index] >= tick_step) ?
                                        remaining[active_index] - tick_step : '0;
              if (remaining[active_index] == '0) begin
                period_states[active_index] = ST_COMPLETED;
                ev = EV_COMPLETED;
              end
            end
          end
        end
        OP_FINISH: begin
          run_flag = 1'b0;
          foreach (period_states[i]) begin
            remaining[i] = durations[i];
            period_states[i] = ST_INACTIVE;
          end
          active_index = '0;
        end
        default: ;
      endcase
      r.current_index = active_index;
      r.remaining_now = (active_index < MAX_PERIODS) ? remaining[active_index[IDX_W-1:0]] : '0;
      r.event_code = ev;
      r.running = run_flag;
      return r;
    endfunction

    function void note_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                            input logic [TIME_W-1:0] dur);
      result_t r;
      r = advance_sequence(op, idx, dur);
      items++;
      if (r.event_code == EV_COMPLETED) completions++;
      if (r.event_code == EV_ALL_DONE) all_done_runs++;
      pending_results.push_back(r);
    endfunction

    function void flag_mismatch(input string what, input result_t want, input result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected idx=%0d rem=%0d ev=%0d run=%0d, got idx=%0d rem=%0d ev=%0d run=%0d",
                 what, want.current_index, want.remaining_now, want.event_code, want.running,
                 got.current_index, got.remaining_now, got.event_code, got.running);
    endfunction

    function void check_result(input result_t got);
      result_t want;
      checked++;
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.current_index !== want.current_index ||
            got.remaining_now !== want.remaining_now ||
            got.event_code !== want.event_code ||
            got.running !== want.running)
          flag_mismatch("result mismatch", want, got);
      end
    endfunction
  endclass

endpackage

[tb/multi_period_countdown_sequencer_unit_test.sv]
// Self-checking testbench for multi_period_countdown_sequencer_unit: directed and
// random item streams under several register settings and idle patterns.
// Depends on mpcs_pkg, mpcs_scoreboard_pkg and the sequencer RTL.
module multi_period_countdown_sequencer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mpcs_pkg::*;
  import mpcs_scoreboard_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 105;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [OP_W-1:0] operation = '0;
  logic [IDX_W-1:0] entry_index = '0;
  logic [TIME_W-1:0] duration_value = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [CNT_W-1:0] current_index;
  logic [TIME_W-1:0] remaining_now;
  logic [EV_W-1:0] event_code;
  logic running;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [TIME_W-1:0] cfg_data = '0;

  int send_idle_pct = 23;
  int recv_idle_pct = 66;
  logic hold_request = 1'b0;
  logic hold_taken;
  int hold_left;
  int quiet_cycles = 0;

  countdown_scoreboard board = new();

  multi_period_countdown_sequencer_unit i_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .operation(operation),
    .entry_index(entry_index),
    .duration_value(duration_value),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .current_index(current_index),
    .remaining_now(remaining_now),
    .event_code(event_code),
    .running(running),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (hold_request && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) board.note_item(operation, entry_index, duration_value);
      if (result_valid && !result_stall)
        board.check_result({current_index, remaining_now, event_code, running});
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("multi_period_countdown_sequencer_unit_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [TIME_W-1:0] pick_duration(input logic [TIME_W-1:0] step);
    logic [63:0] span;
    if ($urandom_range(15) == 0) return $urandom;
    span = 64'(step) * 64'($urandom_range(3)) + 64'($urandom_range(step - 1));
    if (span > 64'hFFFF_FFFF) return $urandom;
    return span[TIME_W-1:0];
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [TIME_W-1:0] dur);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    operation <= op;
    entry_index <= idx;
    duration_value <= dur;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [TIME_W-1:0] step, input logic [CNT_W-1:0] count);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TICK_STEP;
    cfg_data <= step;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_PERIODS_IN_USE;
    cfg_data <= TIME_W'(count);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.tick_step = step;
    board.period_count = count;
  endtask

  initial begin
    logic [TIME_W-1:0] dur;
    logic [TIME_W-1:0] step;
    logic [CNT_W-1:0] count;
    int roll;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int e = 0; e < MAX_PERIODS; e++) begin
      case (e)
        0: dur = 2500;
        1: dur = 0;
        2: dur = '1;
        3: dur = 1000;
        default: dur = TIME_W'((e - 3) * 700);
      endcase
      send_item(OP_LOAD, e[IDX_W-1:0], dur);
    end
    send_item(OP_START, '0, '0);
    repeat (3) send_item(OP_TICK, '0, '0);
    send_item(OP_STOP, '0, '0);
    send_item(OP_TICK, '1, '1);
    send_item(OP_START, '1, '1);
    send_item(OP_TICK, '0, '0);
    send_item(OP_TICK, '0, '0);
    send_item(OP_FINISH, '1, '1);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin step = 1; count = CNT_W'(1); end
        1: begin step = '1; count = CNT_W'(MAX_PERIODS); end
        2: begin
          step = $urandom_range(3000, 1);
          count = CNT_W'($urandom_range(MAX_PERIODS, 1));
        end
        3: begin step = 1000; count = CNT_W'($urandom_range(8, 2)); end
        4: begin step = $urandom_range(500, 1); count = CNT_W'(MAX_PERIODS); end
        default: begin
          step = $urandom | 32'h1;
          count = CNT_W'($urandom_range(MAX_PERIODS, 1));
        end
      endcase
      wait_drained();
      send_idle_pct = (phase < 2) ? 23 : (phase < 4) ? 66 : 0;
      recv_idle_pct = (phase < 2) ? 66 : (phase < 4) ? 23 : 0;
      apply_settings(step, count);
      if (phase == 1) hold_request <= 1'b1;
      for (int e = 0; e < MAX_PERIODS; e++) send_item(OP_LOAD, e[IDX_W-1:0], pick_duration(step));
      send_item(OP_START, IDX_W'($urandom), $urandom);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        roll = $urandom_range(99);
        if (roll < 55) send_item(OP_TICK, IDX_W'($urandom), $urandom);
        else if (roll < 72) send_item(OP_LOAD, IDX_W'($urandom), pick_duration(step));
        else if (roll < 87) send_item(OP_START, IDX_W'($urandom), $urandom);
        else if (roll < 96) send_item(OP_STOP, IDX_W'($urandom), $urandom);
        else send_item(OP_FINISH, IDX_W'($urandom), $urandom);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("Ran %0d items under %0d register settings and three idle patterns;",
             board.items, PHASES + 1);
    $display("%0d results checked, %0d completed periods, %0d sequences run to the end.",
             board.checked, board.completions, board.all_done_runs);
    if (board.mismatches == 0 && board.pending_results.size() == 0)
      $display("multi_period_countdown_sequencer_unit_test: clean");
    else
      $display("multi_period_countdown_sequencer_unit_test: errors");
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/mpcs_pkg.sv
src/mpcs_table.sv
src/mpcs_out_queue.sv
src/multi_period_countdown_sequencer_unit.sv
tb/mpcs_scoreboard_pkg.sv
tb/multi_period_countdown_sequencer_unit_test.sv
